// File: design/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

   localparam int WORD_W = 32;
   localparam int OP_W   = 5;

   typedef logic [OP_W-1:0]   opcode_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam opcode_type OP_PUSH   = 5'd0;
   localparam opcode_type OP_NEG    = 5'd1;
   localparam opcode_type OP_PLUS   = 5'd2;
   localparam opcode_type OP_BITNOT = 5'd3;
   localparam opcode_type OP_LOGNOT = 5'd4;
   localparam opcode_type OP_MUL    = 5'd5;
   localparam opcode_type OP_DIV    = 5'd6;
   localparam opcode_type OP_MOD    = 5'd7;
   localparam opcode_type OP_ADD    = 5'd8;
   localparam opcode_type OP_SUB    = 5'd9;
   localparam opcode_type OP_AND    = 5'd10;
   localparam opcode_type OP_XOR    = 5'd11;
   localparam opcode_type OP_OR     = 5'd12;
   localparam opcode_type OP_SHL    = 5'd13;
   localparam opcode_type OP_SHR    = 5'd14;
   localparam opcode_type OP_LOR    = 5'd15;
   localparam opcode_type OP_LAND   = 5'd16;

   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_COUNT = 3'd1,
      STATUS_UNDER = 3'd2,
      STATUS_OVER  = 3'd3,
      STATUS_DIVZ  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP,
      CELL_LOAD
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
   } div_result_type;

endpackage

// File: design/pse_cell.sv
`timescale 1ns / 1ps

module pse_cell (
   input  logic                  clock,
   input  pse_pkg::cell_cmd_type cmd,
   input  pse_pkg::word_type     d_prev,
   input  pse_pkg::word_type     d_next,
   input  pse_pkg::word_type     d_load,
   output pse_pkg::word_type     q
);
   import pse_pkg::*;

   word_type data_ff;
   word_type data_in;

   always_comb begin
      case (cmd)
         CELL_PUSH: data_in = d_prev;
         CELL_POP:  data_in = d_next;
         CELL_LOAD: data_in = d_load;
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

// File: design/pse_alu.sv
`timescale 1ns / 1ps

module pse_alu (
   input  pse_pkg::opcode_type op,
   input  pse_pkg::word_type   top,
   input  pse_pkg::word_type   second,
   output pse_pkg::word_type   result
);
   import pse_pkg::*;

   word_type   x;
   word_type   y;
   logic [4:0] sh;

   assign x  = second;
   assign y  = top;
   assign sh = top[4:0];

   always_comb begin
      case (op)
         OP_NEG:    result = word_type'(0) - top;
         OP_PLUS:   result = top;
         OP_BITNOT: result = ~top;
         OP_LOGNOT: result = word_type'(top == '0);
         OP_MUL:    result = x * y;
         OP_ADD:    result = x + y;
         OP_SUB:    result = x - y;
         OP_AND:    result = x & y;
         OP_XOR:    result = x ^ y;
         OP_OR:     result = x | y;
         OP_SHL:    result = x << sh;
         OP_SHR:    result = word_type'($signed(x) >>> sh);
         OP_LOR:    result = word_type'((x != '0) || (y != '0));
         OP_LAND:   result = word_type'((x != '0) && (y != '0));
         default:   result = top;
      endcase
   end

endmodule

// File: design/pse_div.sv
`timescale 1ns / 1ps

module pse_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  pse_pkg::word_type       dividend,
   input  pse_pkg::word_type       divisor,
   output logic                    done,
   output pse_pkg::div_result_type result
);
   import pse_pkg::*;

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [4:0] step_ff, step_in;
   word_type   rem_ff, rem_in;
   word_type   quo_ff, quo_in;
   word_type   dvs_ff, dvs_in;
   logic       neg_q_ff, neg_q_in;
   logic       neg_r_ff, neg_r_in;

   logic [WORD_W:0] shifted;
   logic [WORD_W:0] diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      shifted  = {rem_ff, quo_ff[WORD_W-1]};
      diff     = shifted - {1'b0, dvs_ff};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = '0;
         quo_in   = dividend[WORD_W-1] ? word_type'(0) - dividend : dividend;
         dvs_in   = divisor[WORD_W-1] ? word_type'(0) - divisor : divisor;
         neg_q_in = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         neg_r_in = dividend[WORD_W-1];
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done             = done_ff;
   assign result.quotient  = neg_q_ff ? word_type'(0) - quo_ff : quo_ff;
   assign result.remainder = neg_r_ff ? word_type'(0) - rem_ff : rem_ff;

endmodule

// File: design/postfix_stack_evaluator_top.sv
`timescale 1ns / 1ps

// Postfix evaluator over a row of stack cells; the top of stack sits in cell 0. A push
// shifts every cell by one place; a binary op loads cell 0 and shifts the rest up one place.
// A token beat is accepted in ST_IDLE, then executed in ST_EXEC; div and mod wait in
// ST_DIV for the bit-serial divider, which produces one quotient bit per cycle. A last
// token then loads the result beat in ST_EMIT, held while a pending beat sees tready low.
// Stack and error clear after each result beat; no clearing pass after reset.
module postfix_stack_evaluator_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[4:0], token_value[36:5], zero[39:37]
   input  logic        req_tlast,   // last_token
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // value[31:0], status[34:32], zero[39:35]
);
   import pse_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type     err_ff, err_in;
   opcode_type     op_ff, op_in;
   word_type       value_ff, value_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   word_type       rsp_value_ff, rsp_value_in;
   status_type     rsp_status_ff, rsp_status_in;

   cell_cmd_type   cmd_top;
   cell_cmd_type   cmd_rest;
   word_type       load_value;
   word_type       alu_result;
   logic           div_start;
   logic           div_done;
   div_result_type div_result;
   logic           rsp_load;
   logic           req_fire;

   word_type       cell_q [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      word_type d_prev;
      word_type d_next;
      if (i == 0) begin : g_first
         assign d_prev = value_ff;
      end else begin : g_prev
         assign d_prev = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign d_next = '0;
      end else begin : g_next
         assign d_next = cell_q[i+1];
      end
      pse_cell u_cell (
         .clock  (clock),
         .cmd    ((i == 0) ? cmd_top : cmd_rest),
         .d_prev (d_prev),
         .d_next (d_next),
         .d_load (load_value),
         .q      (cell_q[i])
      );
   end

   pse_alu u_alu (
      .op     (op_ff),
      .top    (cell_q[0]),
      .second (cell_q[1]),
      .result (alu_result)
   );

   pse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cell_q[1]),
      .divisor  (cell_q[0]),
      .done     (div_done),
      .result   (div_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      last_ff       <= last_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      cmd_top       = CELL_HOLD;
      cmd_rest      = CELL_HOLD;
      load_value    = alu_result;
      div_start     = 1'b0;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_tdata[OP_W-1:0];
               value_in = req_tdata[OP_W+WORD_W-1:OP_W];
               last_in  = req_tlast;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = last_ff ? ST_EMIT : ST_IDLE;
            if (err_ff == STATUS_OK) begin
               if (op_ff == OP_PUSH) begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     err_in = STATUS_OVER;
                  end else begin
                     cmd_top  = CELL_PUSH;
                     cmd_rest = CELL_PUSH;
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (op_ff inside {[OP_NEG:OP_LOGNOT]}) begin
                  if (count_ff == '0) begin
                     err_in = STATUS_UNDER;
                  end else begin
                     cmd_top = CELL_LOAD;
                  end
               end else if (op_ff inside {[OP_MUL:OP_LAND]}) begin
                  if (count_ff < CNT_W'(2)) begin
                     err_in = STATUS_UNDER;
                  end else if (op_ff inside {OP_DIV, OP_MOD}) begin
                     if (cell_q[0] == '0) begin
                        err_in = STATUS_DIVZ;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end else begin
                     cmd_top  = CELL_LOAD;
                     cmd_rest = CELL_POP;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               load_value = (op_ff == OP_DIV) ? div_result.quotient : div_result.remainder;
               cmd_top    = CELL_LOAD;
               cmd_rest   = CELL_POP;
               count_in   = count_ff - CNT_W'(1);
               state_in   = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (err_ff != STATUS_OK) begin
                  rsp_status_in = err_ff;
                  rsp_value_in  = '0;
               end else if (count_ff != CNT_W'(1)) begin
                  rsp_status_in = STATUS_COUNT;
                  rsp_value_in  = '0;
               end else begin
                  rsp_status_in = STATUS_OK;
                  rsp_value_in  = cell_q[0];
               end
               count_in = '0;
               err_in   = STATUS_OK;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_value_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (count_ff == '0) && (err_ff == STATUS_OK) && rsp_tvalid)
      else $error("stack not cleared after result beat");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide state");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != STATUS_OK) && !rsp_load |=> (err_ff == $past(err_ff)) &&
      (count_ff == $past(count_ff)))
      else $error("sticky error or stack changed");

endmodule

// File: tb/sv/postfix_stack_evaluator_checker.sv
`timescale 1ns / 1ps

module postfix_stack_evaluator_checker #(
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[4:0], token_value[36:5], zero[39:37]
   input  logic        req_tlast,   // last_token
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // value[31:0], status[34:32], zero[39:35]
   output int unsigned mismatch_count,
   output int unsigned results_outstanding
);

   import pse_pkg::*;

   typedef struct packed {
      word_type   value;
      status_type status;
   } outcome_type;

   word_type    stack_mem [STACK_DEPTH];
   int unsigned depth_now;
   status_type  first_err;
   outcome_type results_due [$];
   outcome_type due;
   int unsigned errors_seen;

   function automatic word_type magnitude_of(input word_type x);
      return x[WORD_W-1] ? -x : x;
   endfunction

   function automatic word_type unary_result(input opcode_type op, input word_type x);
      case (op)
         OP_NEG:    return -x;
         OP_PLUS:   return x;
         OP_BITNOT: return ~x;
         default:   return (x == '0) ? 1 : 0;
      endcase
   endfunction

   function automatic word_type binary_result(input opcode_type op, input word_type x,
                                              input word_type y);
      word_type   q;
      word_type   r;
      logic [4:0] sh;
      sh = y[4:0];
      case (op)
         OP_MUL: return x * y;
         OP_DIV: begin
            q = magnitude_of(x) / magnitude_of(y);
            return (x[WORD_W-1] ^ y[WORD_W-1]) ? -q : q;
         end
         OP_MOD: begin
            r = magnitude_of(x) % magnitude_of(y);
            return x[WORD_W-1] ? -r : r;
         end
         OP_ADD: return x + y;
         OP_SUB: return x - y;
         OP_AND: return x & y;
         OP_XOR: return x ^ y;
         OP_OR:  return x | y;
         OP_SHL: return x << sh;
         OP_SHR: return $signed(x) >>> sh;
         OP_LOR: return (x != '0 || y != '0) ? 1 : 0;
         default: return (x != '0 && y != '0) ? 1 : 0;
      endcase
   endfunction

   // first error is sticky until the last token of the expression
   function automatic void advance_stack(input opcode_type op, input word_type v);
      word_type x;
      word_type y;
      if (first_err != STATUS_OK) return;
      if (op == OP_PUSH) begin
         if (depth_now >= STACK_DEPTH) begin
            first_err = STATUS_OVER;
            return;
         end
         stack_mem[depth_now] = v;
         depth_now++;
      end else if (op <= OP_LOGNOT) begin
         if (depth_now < 1) begin
            first_err = STATUS_UNDER;
            return;
         end
         stack_mem[depth_now-1] = unary_result(op, stack_mem[depth_now-1]);
      end else if (op <= OP_LAND) begin
         if (depth_now < 2) begin
            first_err = STATUS_UNDER;
            return;
         end
         y = stack_mem[depth_now-1];
         x = stack_mem[depth_now-2];
         if ((op == OP_DIV || op == OP_MOD) && y == '0) begin
            first_err = STATUS_DIVZ;
            return;
         end
         stack_mem[depth_now-2] = binary_result(op, x, y);
         depth_now--;
      end
   endfunction

   task automatic report_mismatch(input string what);
      errors_seen++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         depth_now = 0;
         first_err = STATUS_OK;
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing due", rsp_tdata));
            end else begin
               due = results_due.pop_front();
               if (rsp_tdata[31:0] !== due.value)
                  report_mismatch($sformatf("value %h, expected %h",
                                            rsp_tdata[31:0], due.value));
               if (rsp_tdata[34:32] !== due.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_tdata[34:32], due.status.name()));
            end
         end
         if (req_tvalid && req_tready) begin
            advance_stack(req_tdata[4:0], req_tdata[36:5]);
            if (req_tlast) begin
               due.value = '0;
               if (first_err != STATUS_OK) begin
                  due.status = first_err;
               end else if (depth_now != 1) begin
                  due.status = STATUS_COUNT;
               end else begin
                  due.status = STATUS_OK;
                  due.value  = stack_mem[0];
               end
               results_due.insert(results_due.size(), due);
               depth_now = 0;
               first_err = STATUS_OK;
            end
         end
      end
      mismatch_count      <= errors_seen;
      results_outstanding <= results_due.size();
   end

endmodule

// File: tb/sv/postfix_stack_evaluator_top_test.sv
`timescale 1ns / 1ps

module postfix_stack_evaluator_top_test;

   import pse_pkg::*;

   localparam int DEPTH = 32;

   typedef struct packed {
      opcode_type op;
      word_type   v;
   } token_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   int unsigned mismatch_count;
   int unsigned results_outstanding;
   int unsigned tokens_sent;
   bit          sender_burst;
   bit          long_hold_done;
   token_type   expr_q [$];

   postfix_stack_evaluator_top #(.STACK_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   postfix_stack_evaluator_checker #(.STACK_DEPTH(DEPTH)) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tlast           (req_tlast),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned idle_cycles(input bit burst);
      int unsigned r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic word_type pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'd1;
         2: return '1;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return $urandom_range(0, 40);
         6: return 32'd0 - $urandom_range(1, 40);
         default: return $urandom;
      endcase
   endfunction

   function automatic token_type binary_token();
      return '{opcode_type'($urandom_range(OP_MUL, OP_LAND)), pick_value()};
   endfunction

   function automatic void build_well_formed(input int unsigned target);
      int unsigned depth;
      depth = 0;
      expr_q.delete();
      while (expr_q.size() < target || depth != 1) begin
         if (depth == 0 || (depth < 2 && expr_q.size() < target)) begin
            expr_q.insert(expr_q.size(), '{OP_PUSH, pick_value()});
            depth++;
         end else if ($urandom_range(0, 4) == 0) begin
            expr_q.insert(expr_q.size(),
                          '{opcode_type'($urandom_range(OP_NEG, OP_LOGNOT)), pick_value()});
         end else if (expr_q.size() < target && $urandom_range(0, 2) == 0) begin
            expr_q.insert(expr_q.size(), '{OP_PUSH, pick_value()});
            depth++;
         end else begin
            expr_q.insert(expr_q.size(), binary_token());
            depth--;
         end
      end
   endfunction

   // near-full stack; more than DEPTH pushes overflows
   function automatic void build_deep();
      int unsigned n;
      n = $urandom_range(DEPTH - 2, DEPTH + 2);
      expr_q.delete();
      repeat (n) expr_q.insert(expr_q.size(), '{OP_PUSH, pick_value()});
      repeat (n - 1) expr_q.insert(expr_q.size(), binary_token());
   endfunction

   function automatic void corrupt_expression();
      int unsigned idx;
      idx = $urandom_range(0, expr_q.size() - 1);
      case ($urandom_range(0, 3))
         0: expr_q[idx].op = opcode_type'($urandom);
         1: if (expr_q.size() > 1) expr_q.delete(idx);
         2: expr_q.insert(idx, '{opcode_type'($urandom), pick_value()});
         default: begin
            expr_q.delete();
            repeat ($urandom_range(1, 6))
               expr_q.insert(expr_q.size(), '{opcode_type'($urandom), $urandom});
         end
      endcase
   endfunction

   task automatic send_token(input opcode_type op, input word_type v, input logic last);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, v, op};
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      tokens_sent++;
      gap = idle_cycles(sender_burst);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic push_token(input word_type v, input logic last);
      send_token(OP_PUSH, v, last);
   endtask

   task automatic send_expression();
      int unsigned i;
      for (i = 0; i < expr_q.size(); i++)
         send_token(expr_q[i].op, expr_q[i].v, i == expr_q.size() - 1);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned kind;
      int unsigned expr_count;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every operator in one chain, with most negative over minus one and shift wrap
      push_token(32'h8000_0000, 1'b0);
      push_token('1, 1'b0);
      send_token(OP_DIV, $urandom, 1'b0);
      push_token(32'h8000_0000, 1'b0);
      push_token('1, 1'b0);
      send_token(OP_MOD, $urandom, 1'b0);
      send_token(OP_ADD, $urandom, 1'b0);
      push_token(32'hFFFF_FFF9, 1'b0);
      push_token(32'd2, 1'b0);
      send_token(OP_MOD, $urandom, 1'b0);
      send_token(OP_SHR, $urandom, 1'b0);
      send_token(OP_BITNOT, $urandom, 1'b0);
      send_token(OP_LOGNOT, $urandom, 1'b0);
      send_token(OP_NEG, $urandom, 1'b0);
      send_token(OP_PLUS, $urandom, 1'b0);
      push_token(32'h7FFF_FFFF, 1'b0);
      send_token(OP_MUL, $urandom, 1'b0);
      push_token(32'd3, 1'b0);
      send_token(OP_SUB, $urandom, 1'b0);
      push_token(32'd5, 1'b0);
      send_token(OP_XOR, $urandom, 1'b0);
      push_token(32'hFFFF_FFF6, 1'b0);
      send_token(OP_AND, $urandom, 1'b0);
      push_token(32'd9, 1'b0);
      send_token(OP_OR, $urandom, 1'b0);
      push_token('0, 1'b0);
      send_token(OP_LOR, $urandom, 1'b0);
      push_token(32'd33, 1'b0);
      send_token(OP_SHL, $urandom, 1'b0);
      push_token(32'd1, 1'b0);
      send_token(OP_LAND, $urandom, 1'b1);
      // divide by zero, then sticky
      push_token(32'd7, 1'b0);
      push_token('0, 1'b0);
      send_token(OP_DIV, $urandom, 1'b0);
      push_token(32'd2, 1'b0);
      send_token(OP_SUB, $urandom, 1'b1);
      // unused opcode, underflow on empty stack
      send_token(opcode_type'(5'd31), $urandom, 1'b0);
      send_token(OP_NEG, $urandom, 1'b0);
      push_token(32'h7FFF_FFFF, 1'b1);
      push_token(32'd1, 1'b0);
      push_token(32'd2, 1'b1);

      expr_count  = 0;
      while (tokens_sent < 650) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 4) build_deep();
         else build_well_formed($urandom_range(1, kind < 14 ? 24 : 8));
         if (kind >= 80) corrupt_expression();
         send_expression();
         expr_count++;
         if (expr_count == 60) wait_for_results();
      end

      wait_for_results();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("postfix_stack_evaluator_top_test: done, clean");
      else
         $display("postfix_stack_evaluator_top_test: done, errors");
      $finish;
   end

   // result side: random ready pattern and one long hold-off
   initial begin
      int unsigned gap;
      bit          burst;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (!long_hold_done && tokens_sent >= 200) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold_done = 1'b1;
         end
         burst = ($urandom_range(0, 3) == 0);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, burst ? 40 : 6)) @(posedge clock);
         gap = idle_cycles(burst);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      #5000000;
      $display("postfix_stack_evaluator_top_test: done, errors");
      $finish;
   end

endmodule

// File: sim.f
design/pse_pkg.sv
design/pse_cell.sv
design/pse_alu.sv
design/pse_div.sv
design/postfix_stack_evaluator_top.sv
tb/sv/postfix_stack_evaluator_checker.sv
tb/sv/postfix_stack_evaluator_top_test.sv
